### sv/pse_pkg.sv
package pse_pkg;

  // field and datapath widths
  localparam int COORD_WIDTH = 24;
  localparam int FRAC_BITS   = 16;
  localparam int VW          = COORD_WIDTH + 8;
  localparam int MAG_W       = COORD_WIDTH + 2;
  localparam int SUM_W       = 2 * MAG_W + 2;
  localparam int ROOT_W      = MAG_W + 1;
  localparam int Q_BITS      = 24;
  localparam int K_W         = Q_BITS + 1;
  localparam int PROD_W      = VW + K_W;

  // request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic signed [VW-1:0]     val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [K_W-1:0]    kq_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [ROOT_W-1:0]        root_t;

  // fixed point constants
  localparam val_t ONE_FX  = val_t'(longint'(1) << FRAC_BITS);
  localparam val_t HALF_FX = val_t'(longint'(1) << (FRAC_BITS - 1));
  localparam val_t R375_FX = val_t'(longint'(3) << (FRAC_BITS - 3));
  localparam val_t R125_FX = val_t'(longint'(1) << (FRAC_BITS - 3));
  localparam val_t R02_FX  = val_t'(((longint'(1) << (FRAC_BITS + 1)) + 5) / 10);
  localparam val_t HS_FX   = HALF_FX - R02_FX;

  // irrational constants with 24 fraction bits
  localparam kq_t K866_Q  = kq_t'(14529495);
  localparam kq_t K577_Q  = kq_t'(9686330);
  localparam kq_t INRAD_Q = kq_t'(7264748);
  localparam kq_t CONE_Q  = kq_t'(7502999);

  localparam longint QHALF_L = longint'(1) << (Q_BITS - 1);
  localparam longint INRAD_L =
    ((longint'(1) << FRAC_BITS) * longint'(INRAD_Q) + QHALF_L) >>> Q_BITS;
  localparam longint LIM_L   = (INRAD_L * longint'(K577_Q) + QHALF_L) >>> Q_BITS;
  localparam val_t INRAD_FX  = val_t'(INRAD_L);
  localparam val_t LIM_FX    = val_t'(LIM_L);

  // output rails
  localparam val_t OUT_MAX = val_t'((longint'(1) << (COORD_WIDTH - 1)) - 1);
  localparam val_t OUT_MIN = -OUT_MAX - val_t'(1);

  typedef enum logic [2:0] {
    SH_SPHERE   = 3'd0,
    SH_CUBE     = 3'd1,
    SH_TORUS    = 3'd2,
    SH_CYLINDER = 3'd3,
    SH_CONE     = 3'd4,
    SH_HEX      = 3'd5,
    SH_RCUBE    = 3'd6,
    SH_NONE     = 3'd7
  } shape_t;

  typedef struct packed {
    shape_t                        kind;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // data carried alongside a root computation
  typedef struct packed {
    logic   valid;
    shape_t kind;
    val_t   y;
    val_t   extra;
    val_t   r1;
    logic   cone_mid;
    prod_t  cprod;
  } side_t;

  function automatic val_t abs_v(input val_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic val_t max_v(input val_t a, input val_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic val_t max0(input val_t v);
    return (v > 0) ? v : val_t'(0);
  endfunction

  function automatic val_t min0(input val_t v);
    return (v < 0) ? v : val_t'(0);
  endfunction

  function automatic mag_t mag_of(input val_t v);
    val_t m;
    m = abs_v(v);
    return m[MAG_W-1:0];
  endfunction

  // divide by 2^24, halves away from zero
  function automatic val_t rnd_q(input prod_t v);
    prod_t m;
    m = (v < 0) ? -v : v;
    m = (m + (prod_t'(1) <<< (Q_BITS - 1))) >>> Q_BITS;
    return (v < 0) ? val_t'(-m) : val_t'(m);
  endfunction

endpackage

### sv/pse_if.sv
interface pse_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [2:0]                             req_type;
  logic signed [pse_pkg::COORD_WIDTH-1:0] px;
  logic signed [pse_pkg::COORD_WIDTH-1:0] py;
  logic signed [pse_pkg::COORD_WIDTH-1:0] pz;

  modport source (output valid, req_type, px, py, pz, input ready);
  modport sink   (input valid, req_type, px, py, pz, output ready);
endinterface

interface pse_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pse_pkg::COORD_WIDTH-1:0] distance;
  logic                                   saturated;

  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface

### sv/primitive_sdf_evaluator_top.sv
// channel | dir | fields                    | request moves
// req     | in  | req_type, px, py, pz      | one point and shape code
// rsp     | out | distance, saturated       | one signed distance
//
// One request per cycle sustained while rsp.ready stays high; each result
// passes through the two pipelined square-root units (29 stages each).
// rst is synchronous and clears the queue and every pipeline valid bit.
// A stalled rsp freezes the back pipeline; the 4-entry queue keeps taking
// requests until it is full, then req.ready drops.
module primitive_sdf_evaluator_top (
  input logic        clk,
  input logic        rst,
  pse_req_if.sink    req,
  pse_rsp_if.source  rsp
);

  logic                q_push;
  logic                q_pop;
  pse_pkg::item_t      q_in;
  pse_pkg::item_t      q_out;
  pse_pkg::q_status_t  q_stat;

  pse_front u_front (
    .req  (req),
    .stat (q_stat),
    .push (q_push),
    .item (q_in)
  );

  pse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .stat      (q_stat)
  );

  pse_back u_back (
    .clk  (clk),
    .rst  (rst),
    .stat (q_stat),
    .item (q_out),
    .pop  (q_pop),
    .rsp  (rsp)
  );

  // no push into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full) else $error("push into full queue");

  // no pop from an empty queue
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty) else $error("pop from empty queue");

  // a clipped distance sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.saturated) |->
      (rsp.distance == pse_pkg::OUT_MAX[pse_pkg::COORD_WIDTH-1:0] ||
       rsp.distance == pse_pkg::OUT_MIN[pse_pkg::COORD_WIDTH-1:0]))
    else $error("saturated distance off the rails");

  // reset empties queue and output
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (q_stat.empty && !rsp.valid)) else $error("state left after reset");

endmodule

### sv/pse_queue.sv
module pse_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pse_pkg::item_t      push_item,
  input  logic                pop,
  output pse_pkg::item_t      pop_item,
  output pse_pkg::q_status_t  stat
);

  pse_pkg::item_t                  mem [pse_pkg::QDEPTH];
  logic [pse_pkg::QPTR_W-1:0]      wr_ptr;
  logic [pse_pkg::QPTR_W-1:0]      rd_ptr;
  logic [pse_pkg::QCNT_W-1:0]      cnt;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == pse_pkg::QPTR_W'(pse_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == pse_pkg::QPTR_W'(pse_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign pop_item   = mem[rd_ptr];
  assign stat.empty = (cnt == '0);
  assign stat.full  = (cnt == pse_pkg::QCNT_W'(pse_pkg::QDEPTH));

endmodule

### sv/pse_front.sv
module pse_front (
  pse_req_if.sink             req,
  input  pse_pkg::q_status_t  stat,
  output logic                push,
  output pse_pkg::item_t      item
);

  // accept while the queue has room
  assign req.ready = !stat.full;
  assign push      = req.valid && !stat.full;

  // classify the shape code, undefined codes become no shape
  always_comb begin
    case (req.req_type) inside
      [3'd0:3'd6]: item.kind = pse_pkg::shape_t'(req.req_type);
      default:     item.kind = pse_pkg::SH_NONE;
    endcase
    item.x = req.px;
    item.y = req.py;
    item.z = req.pz;
  end

endmodule

### sv/pse_sqrt.sv
module pse_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  pse_pkg::mag_t    op_a,
  input  pse_pkg::mag_t    op_b,
  input  pse_pkg::mag_t    op_c,
  input  pse_pkg::side_t   side_in,
  output pse_pkg::root_t   root,
  output pse_pkg::side_t   side_out
);

  localparam int TW = pse_pkg::SUM_W + 1;

  logic [2*pse_pkg::MAG_W-1:0] sq_a;
  logic [2*pse_pkg::MAG_W-1:0] sq_b;
  logic [2*pse_pkg::MAG_W-1:0] sq_c;
  pse_pkg::side_t              sd_sq;
  logic [pse_pkg::SUM_W-1:0]   rem [pse_pkg::ROOT_W+1];
  pse_pkg::root_t              rt  [pse_pkg::ROOT_W+1];
  pse_pkg::side_t              sd  [pse_pkg::ROOT_W+1];

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      sd_sq.valid <= 1'b0;
    end else if (en) begin
      sq_a  <= op_a * op_a;
      sq_b  <= op_b * op_b;
      sq_c  <= op_c * op_c;
      sd_sq <= side_in;
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (en) begin
      rem[0] <= pse_pkg::SUM_W'(sq_a) + pse_pkg::SUM_W'(sq_b) + pse_pkg::SUM_W'(sq_c);
      rt[0]  <= '0;
      sd[0]  <= sd_sq;
    end
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < pse_pkg::ROOT_W; k++) begin : g_bit
    localparam int J = pse_pkg::ROOT_W - 1 - k;
    logic [TW-1:0] trial;

    assign trial = (TW'(rt[k]) << (J + 1)) + (TW'(1) << (2 * J));

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k+1].valid <= 1'b0;
      end else if (en) begin
        if ({1'b0, rem[k]} >= trial) begin
          rem[k+1] <= rem[k] - trial[pse_pkg::SUM_W-1:0];
          rt[k+1]  <= rt[k] | (pse_pkg::root_t'(1) << J);
        end else begin
          rem[k+1] <= rem[k];
          rt[k+1]  <= rt[k];
        end
        sd[k+1] <= sd[k];
      end
    end
  end

  assign root     = rt[pse_pkg::ROOT_W];
  assign side_out = sd[pse_pkg::ROOT_W];

endmodule

### sv/pse_back.sv
module pse_back (
  input  logic                clk,
  input  logic                rst,
  input  pse_pkg::q_status_t  stat,
  input  pse_pkg::item_t      item,
  output logic                pop,
  pse_rsp_if.source           rsp
);

  typedef struct packed {
    logic             valid;
    pse_pkg::shape_t  kind;
    pse_pkg::val_t    x;
    pse_pkg::val_t    y;
    pse_pkg::val_t    z;
    pse_pkg::val_t    a;
    pse_pkg::val_t    b;
    pse_pkg::prod_t   prod;
    pse_pkg::val_t    t;
    pse_pkg::val_t    a2;
    pse_pkg::val_t    b2;
  } pre_t;

  logic            en;
  pre_t            s0, s1, s2, s3, s4, s5, s6;
  pre_t            s0_next, s1_next, s2_next, s3_next, s4_next, s5_next, s6_next;
  pse_pkg::mag_t   u_a, u_b, u_c, u_a_next, u_b_next, u_c_next;
  pse_pkg::side_t  u_side, u_side_next;
  pse_pkg::root_t  root1, root2;
  pse_pkg::side_t  side1, side2;
  pse_pkg::mag_t   m1_a, m1_b, m1_a_next, m1_b_next;
  pse_pkg::side_t  m1_side, m1_side_next;
  pse_pkg::mag_t   m2_a, m2_b;
  pse_pkg::side_t  m2_side, m2_side_next;
  logic            f_valid;
  pse_pkg::val_t   f_d, f_d_next;
  logic            o_valid;
  logic signed [pse_pkg::COORD_WIDTH-1:0] o_dist;
  logic            o_sat;

  // whole pipeline moves when the output register is free or taken
  assign en  = !o_valid || rsp.ready;
  assign pop = en && !stat.empty;

  // request entry: sign extend and take magnitudes
  always_comb begin
    s0_next       = '0;
    s0_next.valid = pop;
    s0_next.kind  = item.kind;
    s0_next.x     = pse_pkg::val_t'(item.x);
    s0_next.y     = pse_pkg::val_t'(item.y);
    s0_next.z     = pse_pkg::val_t'(item.z);
    s0_next.a     = pse_pkg::abs_v(s0_next.x);
    s0_next.b     = pse_pkg::abs_v(s0_next.z);
  end

  // hexagon fold: a * 0.866
  always_comb begin
    s1_next      = s0;
    s1_next.prod = s0.a * pse_pkg::K866_Q;
  end

  // hexagon fold: b * 0.5 - a * 0.866
  always_comb begin
    s2_next      = s1;
    s2_next.prod = (pse_pkg::prod_t'(s1.b) <<< (pse_pkg::Q_BITS - 1)) - s1.prod;
  end

  // hexagon fold: t = min(dot, 0)
  always_comb begin
    s3_next   = s2;
    s3_next.t = pse_pkg::min0(pse_pkg::rnd_q(s2.prod));
  end

  // hexagon fold: 2t * 0.866
  always_comb begin
    s4_next      = s3;
    s4_next.prod = pse_pkg::val_t'(s3.t <<< 1) * pse_pkg::K866_Q;
  end

  // hexagon fold: reflected point
  always_comb begin
    s5_next    = s4;
    s5_next.a2 = s4.a + pse_pkg::rnd_q(s4.prod);
    s5_next.b2 = s4.b - s4.t;
  end

  // hexagon: clamp along the edge, offset by the inradius
  always_comb begin
    pse_pkg::val_t cl;
    if (s5.a2 < -pse_pkg::LIM_FX) begin
      cl = -pse_pkg::LIM_FX;
    end else if (s5.a2 > pse_pkg::LIM_FX) begin
      cl = pse_pkg::LIM_FX;
    end else begin
      cl = s5.a2;
    end
    s6_next    = s5;
    s6_next.a2 = s5.a2 - cl;
    s6_next.b2 = s5.b2 - pse_pkg::INRAD_FX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      s5.valid <= 1'b0;
      s6.valid <= 1'b0;
    end else if (en) begin
      s0 <= s0_next;
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      s6 <= s6_next;
    end
  end

  // operands of the first length
  always_comb begin
    pse_pkg::val_t h, qx, qy, qz;
    h = (s6.kind == pse_pkg::SH_CUBE) ? pse_pkg::HALF_FX : pse_pkg::HS_FX;
    qx = pse_pkg::abs_v(s6.x) - h;
    qy = pse_pkg::abs_v(s6.y) - h;
    qz = pse_pkg::abs_v(s6.z) - h;
    u_side_next       = '0;
    u_side_next.valid = s6.valid;
    u_side_next.kind  = s6.kind;
    u_side_next.y     = s6.y;
    u_a_next = '0;
    u_b_next = '0;
    u_c_next = '0;
    case (s6.kind)
      pse_pkg::SH_SPHERE: begin
        u_a_next = pse_pkg::mag_of(s6.x);
        u_b_next = pse_pkg::mag_of(s6.y);
        u_c_next = pse_pkg::mag_of(s6.z);
      end
      pse_pkg::SH_CUBE, pse_pkg::SH_RCUBE: begin
        u_a_next = pse_pkg::mag_of(pse_pkg::max0(qx));
        u_b_next = pse_pkg::mag_of(pse_pkg::max0(qy));
        u_c_next = pse_pkg::mag_of(pse_pkg::max0(qz));
        u_side_next.extra = pse_pkg::min0(pse_pkg::max_v(qx, pse_pkg::max_v(qy, qz)));
      end
      pse_pkg::SH_TORUS, pse_pkg::SH_CYLINDER, pse_pkg::SH_CONE: begin
        u_a_next = pse_pkg::mag_of(s6.x);
        u_b_next = pse_pkg::mag_of(s6.z);
      end
      pse_pkg::SH_HEX: begin
        u_a_next = pse_pkg::mag_of(s6.a2);
        u_b_next = pse_pkg::mag_of(s6.b2);
        u_side_next.extra = s6.b2;
      end
      default: begin
        u_a_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_side.valid <= 1'b0;
    end else if (en) begin
      u_a    <= u_a_next;
      u_b    <= u_b_next;
      u_c    <= u_c_next;
      u_side <= u_side_next;
    end
  end

  pse_sqrt u_sqrt1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .op_a     (u_a),
    .op_b     (u_b),
    .op_c     (u_c),
    .side_in  (u_side),
    .root     (root1),
    .side_out (side1)
  );

  // operands of the second length
  always_comb begin
    pse_pkg::val_t r1, dx, dy, ya, dh;
    r1 = pse_pkg::val_t'(root1);
    dx = r1 - pse_pkg::HALF_FX;
    dy = pse_pkg::abs_v(side1.y) - pse_pkg::HALF_FX;
    ya = side1.y + pse_pkg::HALF_FX;
    if (side1.extra > 0) begin
      dh = r1;
    end else if (side1.extra < 0) begin
      dh = -r1;
    end else begin
      dh = '0;
    end
    m1_side_next    = side1;
    m1_side_next.r1 = r1;
    m1_a_next = '0;
    m1_b_next = '0;
    case (side1.kind)
      pse_pkg::SH_TORUS: begin
        m1_a_next = pse_pkg::mag_of(r1 - pse_pkg::R375_FX);
        m1_b_next = pse_pkg::mag_of(side1.y);
      end
      pse_pkg::SH_CYLINDER: begin
        m1_a_next = pse_pkg::mag_of(pse_pkg::max0(dx));
        m1_b_next = pse_pkg::mag_of(pse_pkg::max0(dy));
        m1_side_next.extra = pse_pkg::min0(pse_pkg::max_v(dx, dy));
      end
      pse_pkg::SH_CONE: begin
        if (ya > pse_pkg::ONE_FX) begin
          m1_a_next = pse_pkg::mag_of(r1);
          m1_b_next = pse_pkg::mag_of(ya - pse_pkg::ONE_FX);
        end else if (ya < 0) begin
          m1_a_next = pse_pkg::mag_of(r1);
          m1_b_next = pse_pkg::mag_of(ya);
        end else begin
          m1_side_next.cone_mid = 1'b1;
          m1_side_next.extra    = ya + (r1 <<< 1) - pse_pkg::ONE_FX;
        end
      end
      pse_pkg::SH_HEX: begin
        m1_a_next = pse_pkg::mag_of(pse_pkg::max0(dh));
        m1_b_next = pse_pkg::mag_of(pse_pkg::max0(dy));
        m1_side_next.extra = pse_pkg::min0(pse_pkg::max_v(dh, dy));
      end
      default: begin
        m1_a_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_side.valid <= 1'b0;
    end else if (en) begin
      m1_a    <= m1_a_next;
      m1_b    <= m1_b_next;
      m1_side <= m1_side_next;
    end
  end

  // cone slant side: scale by 0.5 / sqrt(1.25)
  always_comb begin
    m2_side_next       = m1_side;
    m2_side_next.cprod = m1_side.extra * pse_pkg::CONE_Q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_side.valid <= 1'b0;
    end else if (en) begin
      m2_a    <= m1_a;
      m2_b    <= m1_b;
      m2_side <= m2_side_next;
    end
  end

  pse_sqrt u_sqrt2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .op_a     (m2_a),
    .op_b     (m2_b),
    .op_c     ('0),
    .side_in  (m2_side),
    .root     (root2),
    .side_out (side2)
  );

  // final distance per shape
  always_comb begin
    pse_pkg::val_t r2;
    r2 = pse_pkg::val_t'(root2);
    case (side2.kind)
      pse_pkg::SH_SPHERE:   f_d_next = side2.r1 - pse_pkg::HALF_FX;
      pse_pkg::SH_CUBE:     f_d_next = side2.r1 + side2.extra;
      pse_pkg::SH_RCUBE:    f_d_next = side2.r1 + side2.extra - pse_pkg::R02_FX;
      pse_pkg::SH_TORUS:    f_d_next = r2 - pse_pkg::R125_FX;
      pse_pkg::SH_CYLINDER: f_d_next = r2 + side2.extra;
      pse_pkg::SH_HEX:      f_d_next = r2 + side2.extra;
      pse_pkg::SH_CONE:     f_d_next = side2.cone_mid ? pse_pkg::rnd_q(side2.cprod) : r2;
      default:              f_d_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= side2.valid;
      f_d     <= f_d_next;
    end
  end

  // output register with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= f_valid;
      if (f_d > pse_pkg::OUT_MAX) begin
        o_dist <= pse_pkg::OUT_MAX[pse_pkg::COORD_WIDTH-1:0];
        o_sat  <= 1'b1;
      end else if (f_d < pse_pkg::OUT_MIN) begin
        o_dist <= pse_pkg::OUT_MIN[pse_pkg::COORD_WIDTH-1:0];
        o_sat  <= 1'b1;
      end else begin
        o_dist <= f_d[pse_pkg::COORD_WIDTH-1:0];
        o_sat  <= 1'b0;
      end
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.distance  = o_dist;
  assign rsp.saturated = o_sat;

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = pse_pkg::COORD_WIDTH;
  localparam longint FX_ONE = longint'(1) << pse_pkg::FRAC_BITS;
  localparam longint FX_HALF = longint'(1) << (pse_pkg::FRAC_BITS - 1);
  localparam longint FX_R375 = longint'(3) << (pse_pkg::FRAC_BITS - 3);
  localparam longint FX_R125 = longint'(1) << (pse_pkg::FRAC_BITS - 3);
  localparam longint FX_R02 = ((longint'(1) << (pse_pkg::FRAC_BITS + 1)) + 5) / 10;
  localparam longint C866 = 14529495;
  localparam longint C577 = 9686330;
  localparam longint CINRAD = 7264748;
  localparam longint CCONE = 7502999;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic signed [W-1:0] distance;
    logic                saturated;
  } dist_t;

  typedef struct {
    pse_pkg::item_t pt;
    bit             drain_first;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pse_req_if req_ch ();
  pse_rsp_if rsp_ch ();

  primitive_sdf_evaluator_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  pending_t pending_q[$];
  dist_t    dist_q[$];
  int       req_count = 0;
  int       rsp_count = 0;
  int       err_count = 0;
  int       quiet_cycles = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  // ---------------------------------------------------------------
  // distance predictor
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b_w;
    res = 0;
    b_w = 64'd1 << 62;
    while (b_w > v) b_w >>= 2;
    while (b_w != 0) begin
      if (v >= res + b_w) begin
        v -= res + b_w;
        res = (res >> 1) + b_w;
      end else begin
        res >>= 1;
      end
      b_w >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned umag(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint hyp(longint a, longint b, longint c);
    longint unsigned x, y, z, lim;
    int sh;
    x = umag(a); y = umag(b); z = umag(c);
    lim = 64'd1 << 31;
    sh = 0;
    // keep the sum of squares in range for huge components
    if (x >= lim || y >= lim || z >= lim) begin
      x >>= 2; y >>= 2; z >>= 2;
      sh = 2;
    end
    return longint'(isqrt(x * x + y * y + z * z) << sh);
  endfunction

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint labs(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // divide by 2^24, halves away from zero
  function automatic longint q24_round(longint v);
    longint unsigned m;
    m = (umag(v) + (64'd1 << 23)) >> 24;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint box_len(longint qx, longint qy, longint qz);
    return hyp(lmax(qx, 0), lmax(qy, 0), lmax(qz, 0)) + lmin(lmax(qx, lmax(qy, qz)), 0);
  endfunction

  function automatic longint hex_len(longint x, longint y, longint z);
    longint a, b, inrad, lim, dot, t, a1, b1, cl, a2, b2, l, dh, dy;
    a = labs(x); b = labs(z);
    inrad = q24_round(FX_ONE * CINRAD);
    lim = q24_round(inrad * C577);
    dot = q24_round(b * (longint'(1) << 23) - a * C866);
    t = lmin(dot, 0);
    a1 = a + q24_round(2 * t * C866);
    b1 = b - t;
    cl = (a1 < -lim) ? -lim : ((a1 > lim) ? lim : a1);
    a2 = a1 - cl;
    b2 = b1 - inrad;
    l = hyp(a2, b2, 0);
    // sign of zero is zero
    dh = (b2 > 0) ? l : ((b2 < 0) ? -l : 0);
    dy = labs(y) - FX_HALF;
    return hyp(lmax(dh, 0), lmax(dy, 0), 0) + lmin(lmax(dh, dy), 0);
  endfunction

  function automatic longint cone_len(longint x, longint y, longint z);
    longint ya, s;
    ya = y + FX_HALF;
    s = hyp(x, z, 0);
    if (ya > FX_ONE) return hyp(s, ya - FX_ONE, 0);
    if (ya < 0) return hyp(s, ya, 0);
    return q24_round((ya + 2 * s - FX_ONE) * CCONE);
  endfunction

  function automatic dist_t predict_distance(pse_pkg::item_t it);
    longint x, y, z, d, hi, lo, dx, dy, hs;
    dist_t r;
    x = it.x; y = it.y; z = it.z;
    hi = (longint'(1) << (W - 1)) - 1;
    lo = -hi - 1;
    case (it.kind)
      pse_pkg::SH_SPHERE:   d = hyp(x, y, z) - FX_HALF;
      pse_pkg::SH_CUBE:     d = box_len(labs(x) - FX_HALF, labs(y) - FX_HALF,
                                        labs(z) - FX_HALF);
      pse_pkg::SH_TORUS:    d = hyp(hyp(x, z, 0) - FX_R375, y, 0) - FX_R125;
      pse_pkg::SH_CYLINDER: begin
        dx = hyp(x, z, 0) - FX_HALF;
        dy = labs(y) - FX_HALF;
        d = lmin(lmax(dx, dy), 0) + hyp(lmax(dx, 0), lmax(dy, 0), 0);
      end
      pse_pkg::SH_CONE:     d = cone_len(x, y, z);
      pse_pkg::SH_HEX:      d = hex_len(x, y, z);
      pse_pkg::SH_RCUBE:    begin
        hs = FX_HALF - FX_R02;
        d = box_len(labs(x) - hs, labs(y) - hs, labs(z) - hs) - FX_R02;
      end
      default:              d = 0;
    endcase
    r.saturated = 1'b0;
    if (d > hi) begin
      d = hi;
      r.saturated = 1'b1;
    end else if (d < lo) begin
      d = lo;
      r.saturated = 1'b1;
    end
    r.distance = d[W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------
  // stimulus
  function automatic void add_point(pse_pkg::shape_t k, longint x, longint y, longint z,
                                    bit drain = 1'b0);
    pending_t p;
    p.pt.kind = k;
    p.pt.x = x[W-1:0];
    p.pt.y = y[W-1:0];
    p.pt.z = z[W-1:0];
    p.drain_first = drain;
    pending_q.push_back(p);
  endfunction

  function automatic longint rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return longint'($urandom_range(2 * 98304)) - 98304;
    if (sel < 85) return longint'($urandom_range(2 * 1048576)) - 1048576;
    return longint'($signed($urandom()) >>> (32 - W));
  endfunction

  initial begin
    longint top, bot;
    pse_pkg::shape_t k;
    top = (longint'(1) << (W - 1)) - 1;
    bot = -(longint'(1) << (W - 1));

    // directed: origin and extremes of every shape
    for (int s = 0; s < 8; s++) add_point(pse_pkg::shape_t'(s), 0, 0, 0);
    for (int s = 0; s < 7; s++) add_point(pse_pkg::shape_t'(s), top, bot, top);
    add_point(pse_pkg::SH_SPHERE, bot, bot, bot);
    add_point(pse_pkg::SH_CUBE, 32768, 32768, 32768);
    // cone above the tip, below the base and on the slant
    add_point(pse_pkg::SH_CONE, 1000, 70000, -500);
    add_point(pse_pkg::SH_CONE, -20000, -90000, 3000);
    add_point(pse_pkg::SH_CONE, 10000, 0, 10000);
    // hex prism exactly on a flat side, so the side term is zero
    add_point(pse_pkg::SH_HEX, 0, 0, 28378);
    add_point(pse_pkg::SH_HEX, 40000, 20000, -5000);
    add_point(pse_pkg::SH_TORUS, 24576, 0, 0);
    add_point(pse_pkg::SH_RCUBE, 30000, -30000, 30000);
    add_point(pse_pkg::SH_NONE, top, top, bot);

    // random points, one pause until every result is back
    for (int i = 0; i < 1500; i++) begin
      k = ($urandom_range(99) < 4) ? pse_pkg::SH_NONE
                                   : pse_pkg::shape_t'($urandom_range(6));
      add_point(k, rand_coord(), rand_coord(), rand_coord(), i == 700);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && dist_q.size() == 0);
    repeat (200) @(posedge clk);
    if (err_count == 0 && dist_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // calm window with no idling on either side
  function automatic bit take_gap();
    if (req_count >= 900 && req_count < 1150) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_q.size() != 0 && !take_gap() &&
          !(pending_q[0].drain_first && (dist_q.size() != 0 ||
            (req_ch.valid && req_ch.ready)))) begin
        req_ch.valid <= 1'b1;
        req_ch.req_type <= pending_q[0].pt.kind;
        req_ch.px <= pending_q[0].pt.x;
        req_ch.py <= pending_q[0].pt.y;
        req_ch.pz <= pending_q[0].pt.z;
        void'(pending_q.pop_front());
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // predict each accepted request
  always @(posedge clk) begin
    pse_pkg::item_t it;
    if (!rst && req_ch.valid && req_ch.ready) begin
      it.kind = pse_pkg::shape_t'(req_ch.req_type);
      it.x = req_ch.px;
      it.y = req_ch.py;
      it.z = req_ch.pz;
      dist_q.push_back(predict_distance(it));
      req_count <= req_count + 1;
    end
  end

  // response ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && req_count >= 300) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !take_gap();
    end
  end

  // response checker
  always @(posedge clk) begin
    dist_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_count <= rsp_count + 1;
      if (dist_q.size() == 0) begin
        err_count <= err_count + 1;
        $display("%0t: unexpected response distance=%0d saturated=%0b", $time,
                 rsp_ch.distance, rsp_ch.saturated);
      end else begin
        want = dist_q.pop_front();
        if (rsp_ch.distance !== want.distance) begin
          err_count <= err_count + 1;
          $display("%0t: distance expected %0d actual %0d", $time,
                   want.distance, rsp_ch.distance);
        end
        if (rsp_ch.saturated !== want.saturated) begin
          err_count <= err_count + 1;
          $display("%0t: saturated expected %0b actual %0b", $time,
                   want.saturated, rsp_ch.saturated);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
